// ----- rtl/gfla_pkg.sv -----
// Package: widths, codes and controller/datapath structs for the slot allocator.
`timescale 1ns / 1ps
package gfla_pkg;

  localparam int unsigned POOL_SLOTS = 1024;
  localparam int unsigned SLOT_W     = $clog2(POOL_SLOTS);
  localparam int unsigned CNT_W      = $clog2(POOL_SLOTS + 1);
  localparam int unsigned CFG_W      = 11;
  localparam int unsigned CFG_IDX_W  = 2;

  localparam logic [CNT_W-1:0] POOL_CNT      = CNT_W'(POOL_SLOTS);
  localparam logic [CFG_W-1:0] REALLOC_RESET = CFG_W'(256);

  localparam logic [CFG_IDX_W-1:0] CFG_REALLOC = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL = CFG_IDX_W'(1);

  localparam logic CMD_ALLOC = 1'b0;
  localparam logic CMD_FREE  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_ROOM = 2'd1,
    ST_NOT_OUT = 2'd2,
    ST_FULL    = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_RDWAIT,
    S_RESP
  } state_e;

  typedef struct packed {
    logic load;       // item taken: latch it, prime pool if not yet done
    logic grow;       // open a new fresh window of up to realloc_size slots, capped by room
    logic pop_stack;  // take the top of the free stack
    logic pop_fresh;  // take the highest fresh slot
    logic take_rd;    // capture stack read data as the granted slot
    logic do_free;    // check and push the freed slot
    logic no_room;    // flag out of capacity
  } ctrl_cmd_t;

  typedef struct packed {
    logic is_free;
    logic pool_empty;
    logic stack_empty;
    logic room_zero;
  } dp_stat_t;

endpackage

// ----- rtl/gfla_if.sv -----
// Interfaces: request and response channels of the slot allocator.
`timescale 1ns / 1ps
interface gfla_req_if;
  import gfla_pkg::*;
  logic              valid;
  logic              ready;
  logic              command;
  logic [SLOT_W-1:0] slot;
  modport source (output valid, command, slot, input ready);
  modport sink (input valid, command, slot, output ready);
endinterface

interface gfla_rsp_if;
  import gfla_pkg::*;
  logic              valid;
  logic              ready;
  logic [SLOT_W-1:0] granted_slot;
  logic [1:0]        status;
  logic [CNT_W-1:0]  allocated_total;
  logic [CNT_W-1:0]  available_count;
  modport source (output valid, granted_slot, status, allocated_total, available_count,
                  input ready);
  modport sink (input valid, granted_slot, status, allocated_total, available_count,
                output ready);
endinterface

// ----- rtl/gfla_ram.sv -----
// Generic single write port RAM with registered read.
`timescale 1ns / 1ps
module gfla_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/gfla_ctrl.sv -----
// Controller: sequences one request through the datapath.
`timescale 1ns / 1ps
module gfla_ctrl import gfla_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      req_valid_i,
  output logic      req_ready_o,
  output logic      rsp_valid_o,
  input  logic      rsp_ready_i,
  input  dp_stat_t  stat_i,
  output ctrl_cmd_t cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    req_ready_o = 1'b0;
    rsp_valid_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_EXEC;
        end
      end
      S_EXEC: begin
        if (stat_i.is_free) begin
          cmd_o.do_free = 1'b1;
          state_d       = S_RESP;
        end else if (stat_i.pool_empty) begin
          if (stat_i.room_zero) begin
            cmd_o.no_room = 1'b1;
            state_d       = S_RESP;
          end else begin
            // new window opened; pop from it on the next pass
            cmd_o.grow = 1'b1;
          end
        end else if (!stat_i.stack_empty) begin
          cmd_o.pop_stack = 1'b1;
          state_d         = S_RDWAIT;
        end else begin
          cmd_o.pop_fresh = 1'b1;
          state_d         = S_RESP;
        end
      end
      S_RDWAIT: begin
        cmd_o.take_rd = 1'b1;
        state_d       = S_RESP;
      end
      S_RESP: begin
        rsp_valid_o = 1'b1;
        if (rsp_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/gfla_dp.sv -----
// Datapath: config registers, pool counters, free stack and result registers.
`timescale 1ns / 1ps
module gfla_dp import gfla_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 req_command_i,
  input  logic [SLOT_W-1:0]    req_slot_i,
  input  ctrl_cmd_t            cmd_i,
  output dp_stat_t             stat_o,
  output logic [SLOT_W-1:0]    granted_slot_o,
  output logic [1:0]           status_o,
  output logic [CNT_W-1:0]     allocated_total_o,
  output logic [CNT_W-1:0]     available_count_o
);

  logic [CFG_W-1:0]  realloc_q, initial_q;
  logic              primed_q;
  logic              cmd_q;
  logic [SLOT_W-1:0] slot_q;
  logic [CNT_W-1:0]  depth_q, low_q, top_q, added_q;
  logic [SLOT_W-1:0] granted_q;
  status_e           status_q;

  logic [CFG_W-1:0]  want;
  logic [CNT_W-1:0]  room, grow_n, avail, slot_ext;
  logic              not_out, full, push;
  logic [SLOT_W-1:0] rd_data;

  assign want     = cmd_i.load ? initial_q : realloc_q;
  assign room     = POOL_CNT - added_q;
  assign grow_n   = (CNT_W'(want) < room) ? CNT_W'(want) : room;
  assign avail    = depth_q + (top_q - low_q);
  assign slot_ext = CNT_W'(slot_q);
  assign not_out  = (slot_ext >= added_q) || ((slot_ext >= low_q) && (slot_ext < top_q));
  assign full     = (avail >= added_q) || (depth_q >= POOL_CNT);
  assign push     = cmd_i.do_free && !not_out && !full;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      realloc_q <= REALLOC_RESET;
      initial_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_REALLOC: realloc_q <= (cfg_wdata_i == '0) ? CFG_W'(1) : cfg_wdata_i;
        CFG_INITIAL: initial_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      primed_q <= 1'b0;
      depth_q  <= '0;
      low_q    <= '0;
      top_q    <= '0;
      added_q  <= '0;
    end else begin
      if ((cmd_i.load && !primed_q) || cmd_i.grow) begin
        primed_q <= 1'b1;
        low_q    <= added_q;
        top_q    <= added_q + grow_n;
        added_q  <= added_q + grow_n;
      end
      if (cmd_i.pop_stack) begin
        depth_q <= depth_q - CNT_W'(1);
      end
      if (cmd_i.pop_fresh) begin
        top_q <= top_q - CNT_W'(1);
      end
      if (push) begin
        depth_q <= depth_q + CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cmd_q     <= req_command_i;
      slot_q    <= req_slot_i;
      granted_q <= '0;
      status_q  <= ST_OK;
    end
    if (cmd_i.no_room) begin
      status_q <= ST_NO_ROOM;
    end
    if (cmd_i.pop_fresh) begin
      granted_q <= SLOT_W'(top_q - CNT_W'(1));
    end
    if (cmd_i.take_rd) begin
      granted_q <= rd_data;
    end
    if (cmd_i.do_free) begin
      if (not_out) begin
        status_q <= ST_NOT_OUT;
      end else if (full) begin
        status_q <= ST_FULL;
      end
    end
  end

  gfla_ram #(
    .WIDTH(SLOT_W),
    .DEPTH(POOL_SLOTS)
  ) u_stack (
    .clk_i  (clk_i),
    .we_i   (push),
    .waddr_i(depth_q[SLOT_W-1:0]),
    .wdata_i(slot_q),
    .raddr_i(SLOT_W'(depth_q - CNT_W'(1))),
    .rdata_o(rd_data)
  );

  assign stat_o.is_free     = (cmd_q == CMD_FREE);
  assign stat_o.pool_empty  = (depth_q == '0) && (top_q == low_q);
  assign stat_o.stack_empty = (depth_q == '0);
  assign stat_o.room_zero   = (room == '0);

  assign granted_slot_o    = granted_q;
  assign status_o          = status_q;
  assign allocated_total_o = added_q;
  assign available_count_o = avail;

endmodule

// ----- rtl/growable_free_list_slot_allocator_top.sv -----
// Top level: LIFO slot allocator with growable fresh pool.
//
//  channel | dir | handshake     | payload
//  req     | in  | valid / ready | command, slot
//  rsp     | out | valid / ready | granted_slot, status, allocated_total, available_count
//  cfg     | in  | cfg_we_i      | cfg_idx_i, cfg_wdata_i
//
// One item at a time: after the accept the controller steps through EXEC to RESP for a fresh
// pop or a free, through EXEC and RDWAIT for a pop from the free stack (registered stack RAM
// read), and through EXEC once more first when the pool has to grow.
// The result holds until taken; req is ready again the cycle after.
// No clearing pass after reset.
`timescale 1ns / 1ps
module growable_free_list_slot_allocator_top import gfla_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  gfla_req_if.sink             req,
  gfla_rsp_if.source           rsp,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i
);

  ctrl_cmd_t ctrl_cmd;
  dp_stat_t  dp_stat;

  gfla_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(req.valid),
    .req_ready_o(req.ready),
    .rsp_valid_o(rsp.valid),
    .rsp_ready_i(rsp.ready),
    .stat_i     (dp_stat),
    .cmd_o      (ctrl_cmd)
  );

  gfla_dp u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .req_command_i    (req.command),
    .req_slot_i       (req.slot),
    .cmd_i            (ctrl_cmd),
    .stat_o           (dp_stat),
    .granted_slot_o   (rsp.granted_slot),
    .status_o         (rsp.status),
    .allocated_total_o(rsp.allocated_total),
    .available_count_o(rsp.available_count)
  );

`ifndef SYNTHESIS
  a_one_side: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req.ready |-> !rsp.valid)
    else $error("request ready while a result is pending");

  a_no_early_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req.valid && req.ready) |=> !rsp.valid)
    else $error("result shown the cycle after accept");

  a_avail_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp.valid |-> (rsp.available_count <= rsp.allocated_total))
    else $error("available count exceeds slots added");

  a_push_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(ctrl_cmd.pop_stack && ctrl_cmd.do_free))
    else $error("stack pop and push in the same cycle");
`endif

endmodule
